### src/pes_pkg.sv
package pes_pkg;

  localparam int PES_NUM_CHANNELS = 16;
  localparam int PES_MAX_CHANNELS = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_SIGALL = 2'd3;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_FREE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] period;
    logic [30:0] start_time;
    logic [3:0]  slot;
    logic [30:0] cur_time;
  } in_word_t;

  typedef struct packed {
    logic [15:0] fire_mask;
    logic [3:0]  assigned_slot;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DRAIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the accepted word, clear the mask
    logic exec;    // run add / remove / signal-all
    logic rd_en;   // issue a table read for the tick sweep
    logic finish;  // emit the tick result
  } cmd_t;

endpackage

### src/pes_ctrl.sv
module pes_ctrl
  import pes_pkg::*;
#(
  parameter int NUM_CHANNELS = PES_NUM_CHANNELS,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    op,
  output logic          busy,
  output cmd_t          cmd,
  output logic [CW-1:0] rd_addr
);

  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CHANNELS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          state_nxt = (op == OP_TICK) ? S_SWEEP : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = cnt_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy)
    else $error("accepted word did not make the block busy");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && cnt_r == LAST_IDX) |=> cmd.finish)
    else $error("sweep end not followed by finish");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !busy)
    else $error("exec cycle not followed by idle");

endmodule

### src/pes_dp.sv
module pes_dp
  import pes_pkg::*;
#(
  parameter int NUM_CHANNELS = PES_NUM_CHANNELS,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_word_t      in_word,
  input  cmd_t          cmd,
  input  logic [CW-1:0] rd_addr,
  output logic          out_strobe,
  output out_word_t     out_word
);

  in_word_t              item_r;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;

  logic [30:0] period_mem [NUM_CHANNELS];
  logic [32:0] last_mem   [NUM_CHANNELS];
  logic [30:0] period_q_r;
  logic [32:0] last_q_r;

  logic          rd_vld_r;
  logic [CW-1:0] idx_d_r;
  logic [15:0]   mask_r, mask_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic          free_found;
  logic [CW-1:0] free_idx;
  logic          slot_ok;
  logic [CW-1:0] slot_idx;
  logic          do_add;

  logic signed [33:0] due;
  logic signed [33:0] now;
  logic               hit;

  logic          per_we;
  logic          last_we;
  logic [CW-1:0] wr_addr;
  logic [32:0]   last_wdata;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = CW'(i);
      end
    end
  end

  assign slot_ok  = ({28'd0, item_r.slot} < 32'(NUM_CHANNELS));
  assign slot_idx = item_r.slot[CW-1:0];
  assign do_add   = cmd.exec && (item_r.op == OP_ADD) && free_found;

  // tick compare on the entry read last cycle
  assign due = $signed({last_q_r[32], last_q_r}) + $signed({3'b000, period_q_r});
  assign now = $signed({3'b000, item_r.cur_time});
  assign hit = rd_vld_r && valid_r[idx_d_r] && (now >= due);

  assign mask_nxt = mask_r | (hit ? (16'd1 << idx_d_r) : 16'd0);

  always_comb begin
    per_we     = do_add;
    last_we    = do_add || hit;
    wr_addr    = do_add ? free_idx : idx_d_r;
    last_wdata = do_add ? ({2'b00, item_r.start_time} - {2'b00, item_r.period})
                        : due[32:0];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[wr_addr] <= item_r.period;
    end
    period_q_r <= period_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[wr_addr] <= last_wdata;
    end
    last_q_r <= last_mem[rd_addr];
  end

  always_comb begin
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;
    if (cmd.exec) begin
      out_strobe_nxt = 1'b1;
      case (item_r.op)
        OP_ADD: begin
          if (free_found) begin
            valid_nxt[free_idx]        = 1'b1;
            out_word_nxt.assigned_slot = 4'(free_idx);
          end else begin
            out_word_nxt.status = STS_FULL;
          end
        end
        OP_REMOVE: begin
          if (slot_ok && valid_r[slot_idx]) begin
            valid_nxt[slot_idx] = 1'b0;
          end else begin
            out_word_nxt.status = STS_FREE;
          end
        end
        OP_SIGALL: begin
          out_word_nxt.fire_mask = 16'(valid_r);
        end
        default: begin
        end
      endcase
    end else if (cmd.finish) begin
      out_strobe_nxt         = 1'b1;
      out_word_nxt.fire_mask = mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
    end
    idx_d_r    <= rd_addr;
    out_word_r <= out_word_nxt;
    if (cmd.load) begin
      mask_r <= '0;
    end else if (rd_vld_r) begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      rd_vld_r     <= cmd.rd_en;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("back-to-back result strobes");

  a_sweep_no_exec: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> !cmd.exec)
    else $error("table op during tick sweep");

  a_err_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.status != STS_OK) |-> (out_word_r.fire_mask == 16'd0))
    else $error("error result carries a fire mask");

endmodule

### src/periodic_event_scheduler_top.sv
// Channel   Ports                      Direction  Handshake
// input     start, busy, in_word       in         taken when start & !busy
// result    out_strobe, out_word       out        one-cycle strobe, no backpressure
//
// Add, remove and signal-all pass from accept through the EXEC state and the
// result register to the strobe. A tick passes through SWEEP and DRAIN: the
// sweep reads one channel a cycle from the period / last-fired memories, whose
// single registered read port sets the pace.
// Reset clears the valid bits and control; table entries stay undefined until added.
// The receiver cannot stall; busy stays high until the result strobe is issued.
module periodic_event_scheduler_top
  import pes_pkg::*;
#(
  parameter int NUM_CHANNELS = PES_NUM_CHANNELS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cmd_t          cmd;
  logic [CW-1:0] rd_addr;

  // sequencer: accept, dispatch, channel sweep
  pes_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_word.op),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  // channel table, tick compare and result register
  pes_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
